// File: rtl/core/lat_pkg.sv
package lat_pkg;

	localparam int MAX_ROWS = 64;
	localparam int MAX_COLS = 64;
	localparam int ROW_W = $clog2(MAX_ROWS);
	localparam int COL_W = 6;
	localparam int SIZE_W = 7;
	localparam int CNT_W = $clog2(MAX_ROWS + 1);
	localparam logic [1:0] LIVE_KEEP = 2'd2;
	localparam logic [2:0] ADDR_ROWS = 3'd0;
	localparam logic [2:0] ADDR_COLS = 3'd4;

	typedef enum logic [1:0] {
		CMD_WRITE = 2'd0,
		CMD_READ = 2'd1,
		CMD_EVOLVE = 2'd2,
		CMD_CLEAR = 2'd3
	} cmd_t;

	typedef struct packed {
		logic [1:0] cmd;
		logic [5:0] row;
		logic [5:0] col;
		logic alive;
	} req_t;

	typedef struct packed {
		logic cell_value;
		logic [31:0] generation;
	} rsp_t;

	typedef struct packed {
		logic shift;
		logic load;
		logic clear;
		logic [MAX_COLS-1:0] wr_mask;
		logic wr_val;
		logic [ROW_W-1:0] wr_row;
		logic [MAX_COLS-1:0] col_en;
		logic [COL_W-1:0] last_col;
	} cell_ctl_t;

endpackage

// File: rtl/core/lat_row_cell.sv
module lat_row_cell (
	input  logic clk,
	input  logic arst_n,
	input  lat_pkg::cell_ctl_t ctl,
	input  logic [lat_pkg::ROW_W-1:0] my_row,
	input  logic en_row,
	input  logic [lat_pkg::MAX_COLS-1:0] load_row,
	input  logic [lat_pkg::MAX_COLS-1:0] shift_in,
	output logic [lat_pkg::MAX_COLS-1:0] bits_q
);
	logic [lat_pkg::MAX_COLS-1:0] nxt;

	always_comb begin
		nxt = bits_q;
		if (ctl.clear) begin
			nxt = '0;
		end else if (ctl.shift) begin
			nxt = shift_in;
		end else if (ctl.load) begin
			if (en_row) begin
				nxt = (bits_q & ~ctl.col_en) | (load_row & ctl.col_en);
			end
		end else if (ctl.wr_row == my_row) begin
			nxt = (bits_q & ~ctl.wr_mask) | ({lat_pkg::MAX_COLS{ctl.wr_val}} & ctl.wr_mask);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bits_q <= '0;
		end else begin
			bits_q <= nxt;
		end
	end
endmodule

// File: rtl/core/lat_rule_row.sv
module lat_rule_row (
	input  logic [lat_pkg::MAX_COLS-1:0] up,
	input  logic [lat_pkg::MAX_COLS-1:0] mid,
	input  logic [lat_pkg::MAX_COLS-1:0] dn,
	input  logic [lat_pkg::COL_W-1:0] last_col,
	output logic [lat_pkg::MAX_COLS-1:0] nxt
);
	always_comb begin
		for (int c = 0; c < lat_pkg::MAX_COLS; c++) begin
			logic [lat_pkg::COL_W-1:0] l, r;
			logic [3:0] n;
			l = (c[lat_pkg::COL_W-1:0] == '0) ? last_col : lat_pkg::COL_W'(c - 1);
			r = (c[lat_pkg::COL_W-1:0] == last_col) ? '0 : lat_pkg::COL_W'(c + 1);
			n = 4'(up[l]) + 4'(up[c]) + 4'(up[r]) + 4'(mid[l]) + 4'(mid[r])
				+ 4'(dn[l]) + 4'(dn[c]) + 4'(dn[r]);
			nxt[c] = (n == 4'd3) || ((n == 4'(lat_pkg::LIVE_KEEP)) && mid[c]);
		end
	end
endmodule

// File: rtl/core/life_automaton_torus_engine_unit.sv
// Game of Life engine on a torus of up to 64 by 64 cells.
// Commands enter on start with req while busy is low; one transfer per command.
// Each command returns one rsp marked by done for exactly one cycle.
// Write, read and clear raise done in the cycle after they are accepted.
// Evolve rotates the row chain once around all 64 row cells, one row per cycle,
// computing each new row from the row at the head, the row above it held aside
// and the row below it (the saved first row for the last row), then raises done.
// The wrapped first and last rows are saved before the rotation begins.
// Size registers sit on the APB port at byte 0 (rows) and 4 (columns); values
// of 0 act as 1 and values above 64 act as 64. Write them only while idle.
// Reset clears the grid and generation count and sets both sizes to 64.
// The receiver cannot stall; results are dropped if not taken.
module life_automaton_torus_engine_unit (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  lat_pkg::req_t req,
	output logic done,
	output lat_pkg::rsp_t rsp,
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [2:0] paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);
	localparam int R = lat_pkg::MAX_ROWS;
	localparam int C = lat_pkg::MAX_COLS;
	localparam int RW = lat_pkg::ROW_W;

	typedef enum logic [1:0] {ST_IDLE = 2'b01, ST_EVO = 2'b10} state_t;

	state_t state_q;
	logic [lat_pkg::SIZE_W-1:0] rows_q, cols_q;
	logic [31:0] gen_q;
	logic [lat_pkg::CNT_W-1:0] cnt_q;
	logic [C-1:0] prev_q, first_q;
	logic done_q, val_q;
	logic [C-1:0] bits [R];
	logic [C-1:0] newrow;
	lat_pkg::cell_ctl_t ctl;
	logic [lat_pkg::SIZE_W-1:0] er, ec;
	logic in_range, acc, evo_go;
	logic [RW-1:0] last_row, cur;
	logic [C-1:0] up, dn;

	assign pready = 1'b1;
	assign prdata = (paddr == lat_pkg::ADDR_COLS) ? 32'(cols_q) : 32'(rows_q);
	assign er = (rows_q == '0) ? 7'd1 : (rows_q > 7'(R)) ? 7'(R) : rows_q;
	assign ec = (cols_q == '0) ? 7'd1 : (cols_q > 7'(C)) ? 7'(C) : cols_q;
	assign last_row = RW'(er - 7'd1);
	assign in_range = (7'(req.row) < er) && (7'(req.col) < ec);
	assign acc = start && !busy;
	assign busy = (state_q != ST_IDLE);
	assign cur = RW'(cnt_q);
	assign evo_go = (state_q == ST_EVO) && (cnt_q != '0) && (cnt_q <= lat_pkg::CNT_W'(R));

	// Row at head of chain (bits[0]) is row cur-1 during rotation step cnt.
	always_comb begin
		up = prev_q;
		dn = ((cur - RW'(1)) == last_row) ? first_q : bits[1];
		if (cur == RW'(1) && last_row == '0) dn = bits[0];
	end

	lat_rule_row u_rule (
		.up(up), .mid(bits[0]), .dn(dn),
		.last_col(6'(ec - 7'd1)), .nxt(newrow)
	);

	always_comb begin
		ctl = '0;
		ctl.wr_row = req.row[RW-1:0];
		ctl.wr_val = req.alive;
		ctl.last_col = 6'(ec - 7'd1);
		for (int c = 0; c < C; c++) ctl.col_en[c] = (7'(c) < ec);
		if (acc && req.cmd == lat_pkg::CMD_WRITE && in_range) ctl.wr_mask[req.col] = 1'b1;
		if (acc && req.cmd == lat_pkg::CMD_CLEAR) ctl.clear = 1'b1;
		if (evo_go) ctl.shift = 1'b1;
	end

	for (genvar i = 0; i < R; i++) begin : g_row
		logic [C-1:0] sin;
		logic en_row;
		always_comb begin
			if (i == R - 1) begin
				en_row = ((cur - RW'(1)) <= last_row);
				sin = en_row ? ((bits[0] & ~ctl.col_en) | (newrow & ctl.col_en)) : bits[0];
			end else begin
				en_row = 1'b0;
				sin = bits[i+1];
			end
		end
		lat_row_cell u_cell (
			.clk(clk), .arst_n(arst_n), .ctl(ctl), .my_row(RW'(i)),
			.en_row(en_row), .load_row('0), .shift_in(sin), .bits_q(bits[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			rows_q <= 7'(R);
			cols_q <= 7'(C);
			gen_q <= '0;
			cnt_q <= '0;
			done_q <= 1'b0;
			val_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (psel && penable && pwrite) begin
				if (paddr == lat_pkg::ADDR_COLS) cols_q <= pwdata[6:0];
				else if (paddr == lat_pkg::ADDR_ROWS) rows_q <= pwdata[6:0];
			end
			unique case (state_q)
				ST_IDLE: begin
					if (acc) begin
						val_q <= (req.cmd == lat_pkg::CMD_READ) && in_range
							&& bits[req.row[RW-1:0]][req.col];
						if (req.cmd == lat_pkg::CMD_EVOLVE) begin
							state_q <= ST_EVO;
							cnt_q <= '0;
						end else begin
							done_q <= 1'b1;
						end
					end
				end
				ST_EVO: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == lat_pkg::CNT_W'(R)) begin
						state_q <= ST_IDLE;
						gen_q <= gen_q + 32'd1;
						done_q <= 1'b1;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_EVO && cnt_q == '0) begin
			first_q <= bits[0];
			prev_q <= bits[last_row];
		end else if (evo_go) begin
			prev_q <= bits[0];
		end
	end

	assign done = done_q;
	assign rsp.cell_value = val_q;
	assign rsp.generation = gen_q;

`ifndef ASSERT_OFF
	a_busy_evo: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && req.cmd == lat_pkg::CMD_EVOLVE) |=> busy)
		else $error("evolve did not raise busy");
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("done while busy");
	a_gen_step: assert property (@(posedge clk) disable iff (!arst_n)
		(gen_q != $past(gen_q)) |-> done)
		else $error("generation moved without result");
`endif
endmodule

// File: test/life_torus_checker.sv
`timescale 1ns / 1ps
module life_torus_checker (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic busy,
	input  lat_pkg::req_t req,
	input  logic done,
	input  lat_pkg::rsp_t rsp,
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [2:0] paddr,
	input  logic [31:0] pwdata,
	input  logic pready,
	output int fail_count,
	output int pending
);
	logic [63:0] grid_m [64];
	logic [31:0] gen_m;
	logic [6:0] rows_reg;
	logic [6:0] cols_reg;
	lat_pkg::rsp_t rsp_queue[$];

	assign pending = rsp_queue.size();

	function automatic int clamp_size(logic [6:0] v);
		if (v == 0) return 1;
		if (v > 64) return 64;
		return v;
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("%0t mismatch %s: got %0h want %0h", $realtime, what, got, want);
		fail_count++;
	endtask

	task automatic next_generation();
		logic [63:0] old_g [64];
		int nr, nc, cnt;
		logic self_b, nxt;
		nr = clamp_size(rows_reg);
		nc = clamp_size(cols_reg);
		old_g = grid_m;
		for (int r = 0; r < nr; r++) begin
			for (int c = 0; c < nc; c++) begin
				cnt = 0;
				for (int i = -1; i <= 1; i++)
					for (int j = -1; j <= 1; j++)
						if (i != 0 || j != 0)
							cnt += old_g[(r + nr + i) % nr][(c + nc + j) % nc];
				self_b = old_g[r][c];
				if (cnt == 2) nxt = self_b;
				else if (cnt == 3) nxt = 1'b1;
				else nxt = 1'b0;
				grid_m[r][c] = nxt;
			end
		end
		gen_m++;
	endtask

	task automatic apply_command(lat_pkg::req_t q);
		lat_pkg::rsp_t e;
		logic in_range;
		in_range = q.row < clamp_size(rows_reg) && q.col < clamp_size(cols_reg);
		e.cell_value = 1'b0;
		case (lat_pkg::cmd_t'(q.cmd))
			lat_pkg::CMD_WRITE: if (in_range) grid_m[q.row][q.col] = q.alive;
			lat_pkg::CMD_READ: if (in_range) e.cell_value = grid_m[q.row][q.col];
			lat_pkg::CMD_EVOLVE: next_generation();
			default: for (int r = 0; r < 64; r++) grid_m[r] = '0;
		endcase
		e.generation = gen_m;
		rsp_queue = {rsp_queue, e};
	endtask

	always @(posedge clk or negedge arst_n) begin
		lat_pkg::rsp_t e;
		if (!arst_n) begin
			for (int r = 0; r < 64; r++) grid_m[r] = '0;
			gen_m = '0;
			rows_reg = 7'd64;
			cols_reg = 7'd64;
			rsp_queue.delete();
			fail_count = 0;
		end else begin
			if (done) begin
				if (rsp_queue.size() == 0) begin
					report_mismatch("unexpected result", rsp.generation, 32'd0);
				end else begin
					e = rsp_queue.pop_front();
					if (rsp.cell_value !== e.cell_value)
						report_mismatch("cell_value", 32'(rsp.cell_value),
							32'(e.cell_value));
					if (rsp.generation !== e.generation)
						report_mismatch("generation", rsp.generation, e.generation);
				end
			end
			if (start && !busy) apply_command(req);
			if (psel && penable && pwrite && pready) begin
				if (paddr == lat_pkg::ADDR_ROWS) rows_reg = pwdata[6:0];
				else if (paddr == lat_pkg::ADDR_COLS) cols_reg = pwdata[6:0];
			end
		end
	end
endmodule

// File: test/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
	logic clk, arst_n, start, busy, done;
	lat_pkg::req_t req;
	lat_pkg::rsp_t rsp;
	logic psel, penable, pwrite, pready;
	logic [2:0] paddr;
	logic [31:0] pwdata, prdata;
	int fail_count, pending;
	int quiet_from, quiet_to, item_no;

	life_automaton_torus_engine_unit i_dut (.*);

	life_torus_checker i_chk (.*);

	initial begin
		clk = 0;
		forever #6 clk = ~clk;
	end

	initial begin
		#20000000;
		$display("tb_top: FAIL");
		$finish;
	end

	task automatic cfg_write(logic [2:0] a, logic [31:0] d);
		start <= 1'b0;
		while (pending != 0) @(posedge clk);
		repeat (70) @(posedge clk);
		psel <= 1; penable <= 0; pwrite <= 1; paddr <= a; pwdata <= d;
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		psel <= 0; penable <= 0; pwrite <= 0;
	endtask

	task automatic issue(lat_pkg::cmd_t c, logic [5:0] r, logic [5:0] k, logic a);
		if (!(item_no >= quiet_from && item_no < quiet_to))
			while ($urandom_range(99) < 10) begin
				start <= 1'b0;
				@(posedge clk);
			end
		req <= '{cmd: c, row: r, col: k, alive: a};
		start <= 1'b1;
		@(posedge clk);
		while (busy) @(posedge clk);
		item_no++;
	endtask

	task automatic random_phase(int n, int rmax, int cmax);
		int p;
		for (int i = 0; i < n; i++) begin
			p = $urandom_range(99);
			if (p < 45)
				issue(lat_pkg::CMD_WRITE, 6'($urandom_range(rmax)),
					6'($urandom_range(cmax)), 1'($urandom_range(1)));
			else if (p < 75)
				issue(lat_pkg::CMD_READ, 6'($urandom_range(rmax)),
					6'($urandom_range(cmax)), 1'($urandom_range(1)));
			else if (p < 96)
				issue(lat_pkg::CMD_EVOLVE, 6'($urandom), 6'($urandom),
					1'($urandom_range(1)));
			else
				issue(lat_pkg::CMD_CLEAR, 6'($urandom), 6'($urandom),
					1'($urandom_range(1)));
		end
	endtask

	initial begin
		start = 0; req = '0; psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
		item_no = 0; quiet_from = 400; quiet_to = 600;
		arst_n = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		issue(lat_pkg::CMD_READ, 6'd63, 6'd63, 1'b0);
		issue(lat_pkg::CMD_WRITE, 6'd0, 6'd0, 1'b1);
		issue(lat_pkg::CMD_WRITE, 6'd63, 6'd63, 1'b1);
		issue(lat_pkg::CMD_WRITE, 6'd0, 6'd63, 1'b1);
		issue(lat_pkg::CMD_WRITE, 6'd0, 6'd1, 1'b1);
		issue(lat_pkg::CMD_READ, 6'd0, 6'd0, 1'b0);
		issue(lat_pkg::CMD_READ, 6'd63, 6'd63, 1'b1);
		issue(lat_pkg::CMD_EVOLVE, 6'd0, 6'd0, 1'b0);
		issue(lat_pkg::CMD_READ, 6'd63, 6'd0, 1'b0);
		issue(lat_pkg::CMD_READ, 6'd0, 6'd0, 1'b0);
		issue(lat_pkg::CMD_EVOLVE, 6'd63, 6'd63, 1'b1);
		issue(lat_pkg::CMD_CLEAR, 6'd0, 6'd0, 1'b0);
		issue(lat_pkg::CMD_READ, 6'd0, 6'd0, 1'b0);
		cfg_write(lat_pkg::ADDR_ROWS, 32'd0);
		cfg_write(lat_pkg::ADDR_COLS, 32'd1);
		issue(lat_pkg::CMD_WRITE, 6'd0, 6'd0, 1'b1);
		issue(lat_pkg::CMD_WRITE, 6'd5, 6'd5, 1'b1);
		issue(lat_pkg::CMD_EVOLVE, 6'd0, 6'd0, 1'b0);
		issue(lat_pkg::CMD_READ, 6'd0, 6'd0, 1'b0);
		issue(lat_pkg::CMD_READ, 6'd5, 6'd5, 1'b0);
		cfg_write(lat_pkg::ADDR_ROWS, 32'd127);
		cfg_write(lat_pkg::ADDR_COLS, 32'd100);
		issue(lat_pkg::CMD_READ, 6'd5, 6'd5, 1'b0);
		issue(lat_pkg::CMD_READ, 6'd0, 6'd0, 1'b0);
		random_phase(300, 63, 63);
		cfg_write(lat_pkg::ADDR_ROWS, 32'd5);
		cfg_write(lat_pkg::ADDR_COLS, 32'd7);
		random_phase(250, 7, 9);
		cfg_write(lat_pkg::ADDR_ROWS, 32'd1);
		cfg_write(lat_pkg::ADDR_COLS, 32'd64);
		random_phase(150, 3, 63);
		cfg_write(lat_pkg::ADDR_ROWS, 32'd64);
		cfg_write(lat_pkg::ADDR_COLS, 32'd2);
		random_phase(150, 63, 3);
		cfg_write(lat_pkg::ADDR_ROWS, 32'd3);
		cfg_write(lat_pkg::ADDR_COLS, 32'd3);
		random_phase(100, 4, 4);
		cfg_write(lat_pkg::ADDR_ROWS, 32'd64);
		cfg_write(lat_pkg::ADDR_COLS, 32'd64);
		random_phase(75, 63, 63);
		start <= 1'b0;
		fork
			while (pending != 0) @(posedge clk);
			repeat (5000) @(posedge clk);
		join_any
		disable fork;
		repeat (100) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("tb_top: PASS");
		else
			$display("tb_top: FAIL");
		$finish;
	end
endmodule
